FILE: src/owmus_pkg.sv
package owmus_pkg;

    // Buffer depths and the widths that follow from them.
    localparam int TX_DEPTH  = 16;
    localparam int RX_DEPTH  = 16;
    localparam int TX_AW     = $clog2(TX_DEPTH);
    localparam int RX_AW     = $clog2(RX_DEPTH);
    localparam int TXC_W     = $clog2(TX_DEPTH);
    localparam int RXC_W     = $clog2(RX_DEPTH);
    localparam int MAX_DEPTH = (TX_DEPTH > RX_DEPTH) ? TX_DEPTH : RX_DEPTH;
    localparam int BIT_W     = $clog2(MAX_DEPTH * 8);
    localparam int BYTE_W    = BIT_W - 3;

    // Fixed field widths.
    localparam int DATA_W    = 8;
    localparam int KIND_W    = 3;
    localparam int IDX_W     = 4;
    localparam int LEN_W     = 8;
    localparam int CMP_W     = LEN_W + 1;
    localparam int CFG_IDX_W = 3;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    // Depth of the result queue in front of the master port.
    localparam int OUTQ_DEPTH = 3;

    typedef enum logic [KIND_W-1:0] {
        KIND_ECHO,
        KIND_DETECT,
        KIND_SEND,
        KIND_POLL,
        KIND_TX_WRITE,
        KIND_RX_READ
    } t_kind;

    typedef enum logic [3:0] {
        ST_NOINIT,
        ST_DETWAIT,
        ST_DETERR,
        ST_DETDONE,
        ST_SENDSTART,
        ST_SENDERR,
        ST_SENDWAIT,
        ST_SENDDONE,
        ST_RECVWAIT,
        ST_RECVDONE,
        ST_STATBUSY,
        ST_STATEMPTY
    } t_link;

    typedef enum logic [1:0] {
        BAUD_KEEP,
        BAUD_SLOW,
        BAUD_FAST
    } t_baud;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RESET_SLOT,
        CFG_NO_PRESENCE,
        CFG_WRITE_ONE,
        CFG_WRITE_ZERO,
        CFG_READ_SLOT,
        CFG_READ_ONE_ECHO,
        CFG_STATUS_QUERY,
        CFG_STATUS_EMPTY
    } t_cfg_idx;

    typedef struct packed {
        logic [DATA_W-1:0] reset_slot;
        logic [DATA_W-1:0] no_presence;
        logic [DATA_W-1:0] write_one;
        logic [DATA_W-1:0] write_zero;
        logic [DATA_W-1:0] read_slot;
        logic [DATA_W-1:0] read_one_echo;
        logic [DATA_W-1:0] status_query;
        logic [DATA_W-1:0] status_empty;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        reset_slot:    8'd240,
        no_presence:   8'd240,
        write_one:     8'd255,
        write_zero:    8'd0,
        read_slot:     8'd255,
        read_one_echo: 8'd255,
        status_query:  8'd255,
        status_empty:  8'd255
    };

    typedef struct packed {
        t_kind              kind;
        logic [DATA_W-1:0]  echo_byte;
        logic [IDX_W-1:0]   entry_index;
        logic [DATA_W-1:0]  entry_value;
        logic [LEN_W-1:0]   send_length;
        logic [LEN_W-1:0]   receive_length;
    } t_item;

    // Packed so that slot_valid lands in bit 0 of the master tdata.
    typedef struct packed {
        logic               read_ok;
        logic [DATA_W-1:0]  read_value;
        t_link              link_state;
        t_baud              baud_select;
        logic [DATA_W-1:0]  slot_byte;
        logic               slot_valid;
    } t_result;

endpackage

FILE: src/owmus_ram.sv
module owmus_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: src/owmus_core.sv
module owmus_core (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [owmus_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [owmus_pkg::DATA_W-1:0]         i_cfg_data,
    input  logic                                 i_item_valid,
    input  owmus_pkg::t_item                     i_item,
    output logic                                 o_res_valid,
    output owmus_pkg::t_result                   o_res
);

    localparam int BIT_W  = owmus_pkg::BIT_W;
    localparam int BYTE_W = owmus_pkg::BYTE_W;
    localparam int TX_AW  = owmus_pkg::TX_AW;
    localparam int RX_AW  = owmus_pkg::RX_AW;
    localparam int TXC_W  = owmus_pkg::TXC_W;
    localparam int RXC_W  = owmus_pkg::RXC_W;
    localparam int CMP_W  = owmus_pkg::CMP_W;
    localparam int DW     = owmus_pkg::DATA_W;

    owmus_pkg::t_cfg    r_cfg;
    owmus_pkg::t_link   r_mode, n_mode;
    logic [BIT_W-1:0]   r_bit, n_bit;
    logic [DW-1:0]      r_shift, n_shift;
    logic [TXC_W-1:0]   r_tx_count, n_tx_count;
    logic [RXC_W-1:0]   r_rx_count, n_rx_count;

    // Stage after acceptance, waiting for the receive buffer read data.
    logic               r_b_valid;
    owmus_pkg::t_result r_b;

    // Write-through bypass for the transmit prefetch.
    logic               r_fwd_valid;
    logic [DW-1:0]      r_fwd_data;

    logic               slot_v;
    logic [DW-1:0]      slot;
    owmus_pkg::t_baud   baud;
    logic               rd_ok;
    logic               send_en;
    logic [BIT_W-1:0]   send_bc;
    logic [BYTE_W-1:0]  send_byte;
    logic [DW-1:0]      send_src;
    logic [BIT_W-1:0]   recv_bc;
    logic [BYTE_W-1:0]  recv_byte;
    logic [DW-1:0]      recv_shift;
    logic               tx_we;
    logic [TX_AW-1:0]   tx_waddr;
    logic [TX_AW-1:0]   pref_addr;
    logic [DW-1:0]      tx_rdata;
    logic [DW-1:0]      tx_q;
    logic               rx_we;
    logic [RX_AW-1:0]   rx_waddr;
    logic [DW-1:0]      rx_rdata;

    assign tx_waddr = TX_AW'(i_item.entry_index);
    assign tx_q     = r_fwd_valid ? r_fwd_data : tx_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= owmus_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            case (owmus_pkg::t_cfg_idx'(i_cfg_index))
                owmus_pkg::CFG_RESET_SLOT:    r_cfg.reset_slot    <= i_cfg_data;
                owmus_pkg::CFG_NO_PRESENCE:   r_cfg.no_presence   <= i_cfg_data;
                owmus_pkg::CFG_WRITE_ONE:     r_cfg.write_one     <= i_cfg_data;
                owmus_pkg::CFG_WRITE_ZERO:    r_cfg.write_zero    <= i_cfg_data;
                owmus_pkg::CFG_READ_SLOT:     r_cfg.read_slot     <= i_cfg_data;
                owmus_pkg::CFG_READ_ONE_ECHO: r_cfg.read_one_echo <= i_cfg_data;
                owmus_pkg::CFG_STATUS_QUERY:  r_cfg.status_query  <= i_cfg_data;
                owmus_pkg::CFG_STATUS_EMPTY:  r_cfg.status_empty  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_mode     = r_mode;
        n_bit      = r_bit;
        n_shift    = r_shift;
        n_tx_count = r_tx_count;
        n_rx_count = r_rx_count;
        slot_v     = 1'b0;
        slot       = '0;
        baud       = owmus_pkg::BAUD_KEEP;
        rd_ok      = 1'b0;
        send_en    = 1'b0;
        send_bc    = r_bit;
        tx_we      = 1'b0;
        rx_we      = 1'b0;
        recv_bc    = r_bit + 1'b1;
        recv_byte  = recv_bc[BIT_W-1:3];
        recv_shift = {(i_item.echo_byte == r_cfg.read_one_echo), r_shift[DW-1:1]};
        rx_waddr   = RX_AW'(recv_byte - 1'b1);

        if (i_item_valid) begin
            case (i_item.kind)
                owmus_pkg::KIND_ECHO: begin
                    case (r_mode)
                        owmus_pkg::ST_DETWAIT, owmus_pkg::ST_DETERR: begin
                            if (i_item.echo_byte == r_cfg.no_presence) begin
                                n_mode = owmus_pkg::ST_DETERR;
                                slot   = r_cfg.reset_slot;
                                slot_v = 1'b1;
                            end else begin
                                n_mode = owmus_pkg::ST_DETDONE;
                            end
                        end
                        owmus_pkg::ST_SENDSTART, owmus_pkg::ST_SENDERR: begin
                            if (i_item.echo_byte == r_cfg.no_presence) begin
                                n_mode = owmus_pkg::ST_SENDERR;
                                slot   = r_cfg.reset_slot;
                                slot_v = 1'b1;
                            end else begin
                                baud    = owmus_pkg::BAUD_FAST;
                                send_en = 1'b1;
                                send_bc = '0;
                            end
                        end
                        owmus_pkg::ST_SENDWAIT: begin
                            send_en = 1'b1;
                        end
                        owmus_pkg::ST_RECVWAIT: begin
                            n_bit = recv_bc;
                            if (recv_bc[2:0] == 3'd0) begin
                                rx_we = 1'b1;
                                if (recv_byte >= BYTE_W'(r_rx_count)) begin
                                    n_mode  = owmus_pkg::ST_RECVDONE;
                                    n_shift = recv_shift;
                                end else begin
                                    slot    = r_cfg.read_slot;
                                    slot_v  = 1'b1;
                                    n_shift = '0;
                                end
                            end else begin
                                slot    = r_cfg.read_slot;
                                slot_v  = 1'b1;
                                n_shift = recv_shift;
                            end
                        end
                        owmus_pkg::ST_STATBUSY: begin
                            if (i_item.echo_byte == r_cfg.status_empty) begin
                                n_mode = owmus_pkg::ST_STATEMPTY;
                            end
                        end
                        default: ;
                    endcase
                end
                owmus_pkg::KIND_DETECT: begin
                    baud   = owmus_pkg::BAUD_SLOW;
                    slot   = r_cfg.reset_slot;
                    slot_v = 1'b1;
                    n_mode = owmus_pkg::ST_DETWAIT;
                end
                owmus_pkg::KIND_SEND: begin
                    if ((CMP_W'(i_item.send_length) < CMP_W'(owmus_pkg::TX_DEPTH)) &&
                        (CMP_W'(i_item.receive_length) < CMP_W'(owmus_pkg::RX_DEPTH))) begin
                        n_tx_count = TXC_W'(i_item.send_length);
                        n_rx_count = RXC_W'(i_item.receive_length);
                        baud       = owmus_pkg::BAUD_SLOW;
                        slot       = r_cfg.reset_slot;
                        slot_v     = 1'b1;
                        n_mode     = owmus_pkg::ST_SENDSTART;
                    end
                end
                owmus_pkg::KIND_POLL: begin
                    if (r_mode != owmus_pkg::ST_STATEMPTY) begin
                        slot   = r_cfg.status_query;
                        slot_v = 1'b1;
                        n_mode = owmus_pkg::ST_STATBUSY;
                    end
                end
                owmus_pkg::KIND_TX_WRITE: begin
                    tx_we = (CMP_W'(i_item.entry_index) < CMP_W'(owmus_pkg::TX_DEPTH));
                end
                owmus_pkg::KIND_RX_READ: begin
                    rd_ok = (CMP_W'(i_item.entry_index) < CMP_W'(r_rx_count)) &&
                            (CMP_W'(i_item.entry_index) < CMP_W'(owmus_pkg::RX_DEPTH));
                end
                default: ;
            endcase
        end

        // Next write bit, or turn to reading, or finish.
        send_byte = send_bc[BIT_W-1:3];
        send_src  = (send_bc[2:0] == 3'd0) ? tx_q : r_shift;
        if (send_en) begin
            if (send_byte != BYTE_W'(r_tx_count)) begin
                slot    = send_src[0] ? r_cfg.write_one : r_cfg.write_zero;
                slot_v  = 1'b1;
                n_shift = {1'b0, send_src[DW-1:1]};
                n_bit   = send_bc + 1'b1;
                n_mode  = owmus_pkg::ST_SENDWAIT;
            end else if (r_rx_count != '0) begin
                slot    = r_cfg.read_slot;
                slot_v  = 1'b1;
                n_mode  = owmus_pkg::ST_RECVWAIT;
                n_bit   = '0;
                n_shift = '0;
            end else begin
                n_mode  = owmus_pkg::ST_SENDDONE;
                n_bit   = send_bc;
            end
        end

        // The transmit byte the next state would load.
        if ((n_mode == owmus_pkg::ST_SENDSTART) || (n_mode == owmus_pkg::ST_SENDERR)) begin
            pref_addr = '0;
        end else begin
            pref_addr = TX_AW'(n_bit[BIT_W-1:3]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= owmus_pkg::ST_NOINIT;
            r_bit       <= '0;
            r_shift     <= '0;
            r_tx_count  <= '0;
            r_rx_count  <= '0;
            r_b_valid   <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            r_mode      <= n_mode;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_tx_count  <= n_tx_count;
            r_rx_count  <= n_rx_count;
            r_b_valid   <= i_item_valid;
            r_fwd_valid <= tx_we && (tx_waddr == pref_addr);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_data <= i_item.entry_value;
        if (i_item_valid) begin
            r_b.slot_valid  <= slot_v;
            r_b.slot_byte   <= slot;
            r_b.baud_select <= baud;
            r_b.link_state  <= n_mode;
            r_b.read_value  <= '0;
            r_b.read_ok     <= rd_ok;
        end
    end

    owmus_ram #(
        .DEPTH (owmus_pkg::TX_DEPTH),
        .WIDTH (DW)
    ) u_tx_ram (
        .i_clk   (i_clk),
        .i_we    (tx_we),
        .i_waddr (tx_waddr),
        .i_wdata (i_item.entry_value),
        .i_re    (1'b1),
        .i_raddr (pref_addr),
        .o_rdata (tx_rdata)
    );

    owmus_ram #(
        .DEPTH (owmus_pkg::RX_DEPTH),
        .WIDTH (DW)
    ) u_rx_ram (
        .i_clk   (i_clk),
        .i_we    (rx_we),
        .i_waddr (rx_waddr),
        .i_wdata (recv_shift),
        .i_re    (i_item_valid),
        .i_raddr (RX_AW'(i_item.entry_index)),
        .o_rdata (rx_rdata)
    );

    always_comb begin
        o_res            = r_b;
        o_res.read_value = r_b.read_ok ? rx_rdata : '0;
    end

    assign o_res_valid = r_b_valid;

    a_send_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == owmus_pkg::ST_SENDWAIT) |-> (r_bit[BIT_W-1:3] <= BYTE_W'(r_tx_count)))
        else $error("bit counter ran past the transmit length");

    a_recv_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == owmus_pkg::ST_RECVWAIT) |-> (r_bit[BIT_W-1:3] < BYTE_W'(r_rx_count)))
        else $error("bit counter ran past the receive length");

    a_rx_write_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rx_we |-> (i_item_valid && (r_mode == owmus_pkg::ST_RECVWAIT)))
        else $error("receive buffer written outside a receive slot");

endmodule

FILE: src/owmus_outq.sv
module owmus_outq (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  owmus_pkg::t_result i_data,
    input  logic               i_pending,
    output logic               o_space,
    output logic               o_valid,
    output owmus_pkg::t_result o_data,
    input  logic               i_ready
);

    localparam int DEPTH = owmus_pkg::OUTQ_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    owmus_pkg::t_result r_mem [DEPTH];
    logic [PTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               pop;

    assign o_valid = (r_count != '0);
    assign o_data  = r_mem[r_rd_ptr];
    assign pop     = o_valid && i_ready;

    // Room must cover the item still in the stage ahead of the queue.
    assign o_space = (SUM_W'(r_count) + SUM_W'(i_pending)) < SUM_W'(DEPTH);

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !pop) begin
            n_count = r_count + 1'b1;
        end else if (pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> ((r_count < CNT_W'(DEPTH)) || pop))
        else $error("result queue overflow");

    a_push_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |=> o_valid)
        else $error("pushed result not visible");

    a_space_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_space |-> (r_count < CNT_W'(DEPTH)))
        else $error("space reported with a full queue");

endmodule

FILE: src/one_wire_master_uart_sequencer.sv
// Each result is registered in the core and then queued for the master side.
// Throughput: one transaction per cycle while the queue has room; every update is a
// single read-modify-write of the protocol state, with the transmit byte prefetched.
// A three-entry result queue keeps the slave side accepting while results wait.
// Reset (synchronous, active low) clears the protocol state, counters, queue and
// configuration registers; the byte buffers keep their contents and are not cleared.
module one_wire_master_uart_sequencer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Configuration write port: register index and eight data bits.
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // Slave side: the input items.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // tdata: echo_byte [7:0], entry_index [11:8], entry_value [19:12],
    //        send_length [27:20], receive_length [35:28], zero fill [39:36].
    input  logic [owmus_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: kind [2:0].
    input  logic [2:0]  s_axis_tuser,
    // Master side: the result items.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // tdata: slot_valid [0], slot_byte [8:1], baud_select [10:9],
    //        link_state [14:11], read_value [22:15], read_ok [23].
    output logic [owmus_pkg::M_TDATA_W-1:0] m_axis_tdata
);

    owmus_pkg::t_item   item;
    logic               accept;
    logic               res_valid;
    owmus_pkg::t_result res;
    owmus_pkg::t_result q_data;

    // A transaction is taken whenever the queue has room for it and for the
    // result still waiting on the receive buffer read.
    assign accept = s_axis_tvalid && s_axis_tready;

    always_comb begin
        item.kind           = owmus_pkg::t_kind'(s_axis_tuser);
        item.echo_byte      = s_axis_tdata[7:0];
        item.entry_index    = s_axis_tdata[11:8];
        item.entry_value    = s_axis_tdata[19:12];
        item.send_length    = s_axis_tdata[27:20];
        item.receive_length = s_axis_tdata[35:28];
    end

    // The sequencer holds the protocol state and both byte buffers; each
    // accepted transaction updates the state in the cycle it arrives.
    owmus_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_item_valid (accept),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    // The result queue parts the master side from the slave side.
    owmus_outq u_outq (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (res_valid),
        .i_data    (res),
        .i_pending (res_valid),
        .o_space   (s_axis_tready),
        .o_valid   (m_axis_tvalid),
        .o_data    (q_data),
        .i_ready   (m_axis_tready)
    );

    assign m_axis_tdata = q_data;

endmodule
